>>> hdl/tripwire_crossing_direction_defines.svh
// Assertion macros used by the checker file of the tripwire block.
`ifndef TRIPWIRE_CROSSING_DIRECTION_DEFINES_SVH
`define TRIPWIRE_CROSSING_DIRECTION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tcd_pkg.sv
`default_nettype none

package tcd_pkg;

	// Test selected by the func field.
	localparam logic FUNC_INTERSECT = 1'b0;
	localparam logic FUNC_TRIPWIRE  = 1'b1;

	// Crossing direction codes.
	localparam logic [1:0] DIR_NONE   = 2'd0;
	localparam logic [1:0] DIR_A_TO_B = 2'd1;
	localparam logic [1:0] DIR_B_TO_A = 2'd2;

	// One result transaction.
	typedef struct packed {
		logic       crosses;
		logic [1:0] direction;
	} tcd_result_t;

endpackage

`default_nettype wire

>>> hdl/tcd_in_if.sv
`default_nettype none

// Input channel: one motion segment and one alert line per transaction.
interface tcd_in_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [COORD_BITS-1:0] move_start_x;
	logic [COORD_BITS-1:0] move_start_y;
	logic [COORD_BITS-1:0] move_end_x;
	logic [COORD_BITS-1:0] move_end_y;
	logic [COORD_BITS-1:0] line_a_x;
	logic [COORD_BITS-1:0] line_a_y;
	logic [COORD_BITS-1:0] line_b_x;
	logic [COORD_BITS-1:0] line_b_y;

	modport source (
		output valid, func, move_start_x, move_start_y, move_end_x, move_end_y,
		output line_a_x, line_a_y, line_b_x, line_b_y,
		input  ready
	);

	modport sink (
		input  valid, func, move_start_x, move_start_y, move_end_x, move_end_y,
		input  line_a_x, line_a_y, line_b_x, line_b_y,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/tcd_out_if.sv
`default_nettype none

// Result channel: crossing flag and direction per transaction.
interface tcd_out_if;
	logic       valid;
	logic       ready;
	logic       crosses;
	logic [1:0] direction;

	modport source (
		output valid, crosses, direction,
		input  ready
	);

	modport sink (
		input  valid, crosses, direction,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/tcd_geom.sv
`default_nettype none

// Combinational geometry: four cross products, box overlap and the decision.
module tcd_geom #(
	parameter int COORD_BITS = 12
) (
	input  logic                  func,
	input  logic [COORD_BITS-1:0] sx,
	input  logic [COORD_BITS-1:0] sy,
	input  logic [COORD_BITS-1:0] ex,
	input  logic [COORD_BITS-1:0] ey,
	input  logic [COORD_BITS-1:0] ax,
	input  logic [COORD_BITS-1:0] ay,
	input  logic [COORD_BITS-1:0] bx,
	input  logic [COORD_BITS-1:0] by,
	output tcd_pkg::tcd_result_t  res
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int XW = 2 * COORD_BITS + 3;

	// Exact cross product (Q - P) x (T - P).
	function automatic logic signed [XW-1:0] cross3(
		input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
		input logic [COORD_BITS-1:0] qx, input logic [COORD_BITS-1:0] qy,
		input logic [COORD_BITS-1:0] tx, input logic [COORD_BITS-1:0] ty
	);
		logic signed [DW-1:0] dqx, dqy, dtx, dty;
		logic signed [PW-1:0] m1, m2;
		dqx = $signed({1'b0, qx}) - $signed({1'b0, px});
		dqy = $signed({1'b0, qy}) - $signed({1'b0, py});
		dtx = $signed({1'b0, tx}) - $signed({1'b0, px});
		dty = $signed({1'b0, ty}) - $signed({1'b0, py});
		m1 = dqx * dty;
		m2 = dqy * dtx;
		return XW'(m1) - XW'(m2);
	endfunction

	logic signed [XW-1:0] d1, d2, d3, d4;
	logic [3:0] pos, neg, zero;
	logic box_hit, straddle, collinear, zero_len, swap;
	logic [COORD_BITS-1:0] s_xmax, s_xmin, s_ymax, s_ymin;
	logic [COORD_BITS-1:0] l_xmax, l_xmin, l_ymax, l_ymin;
	logic [1:0] dir;

	// Cross products of the motion ends against the line and vice versa.
	assign d1 = cross3(ax, ay, bx, by, sx, sy);
	assign d2 = cross3(ax, ay, bx, by, ex, ey);
	assign d3 = cross3(sx, sy, ex, ey, ax, ay);
	assign d4 = cross3(sx, sy, ex, ey, bx, by);

	// Sign classes of each product.
	always_comb begin
		neg  = {d4[XW-1], d3[XW-1], d2[XW-1], d1[XW-1]};
		zero = {d4 == '0, d3 == '0, d2 == '0, d1 == '0};
		pos  = ~neg & ~zero;
	end

	// Bounding boxes; touching boxes count as overlapping.
	always_comb begin
		s_xmax  = (sx > ex) ? sx : ex;
		s_xmin  = (sx > ex) ? ex : sx;
		s_ymax  = (sy > ey) ? sy : ey;
		s_ymin  = (sy > ey) ? ey : sy;
		l_xmax  = (ax > bx) ? ax : bx;
		l_xmin  = (ax > bx) ? bx : ax;
		l_ymax  = (ay > by) ? ay : by;
		l_ymin  = (ay > by) ? by : ay;
		box_hit = (s_xmax >= l_xmin) && (l_xmax >= s_xmin) &&
			(s_ymax >= l_ymin) && (l_ymax >= s_ymin);
	end

	// Undirected test: strict mutual straddle, or collinear with box overlap.
	always_comb begin
		straddle  = ((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
			((pos[2] && neg[3]) || (neg[2] && pos[3]));
		collinear = &zero;
	end

	// Directed test. Reversing the line negates both end-point products, so
	// the orientation becomes a swap of the sign tests.
	always_comb begin
		zero_len = (sx == ex) && (sy == ey);
		swap     = (ax == bx) ? (ay < by) : (ax > bx);
		dir      = tcd_pkg::DIR_NONE;
		if (!zero_len && box_hit) begin
			if (swap ? (pos[0] && neg[1]) : (neg[0] && pos[1])) begin
				dir = tcd_pkg::DIR_A_TO_B;
			end else if (swap ? (neg[0] && pos[1]) : (pos[0] && neg[1])) begin
				dir = tcd_pkg::DIR_B_TO_A;
			end
		end
	end

	// Result selection by test.
	always_comb begin
		if (func == tcd_pkg::FUNC_INTERSECT) begin
			res.crosses   = straddle || (collinear && box_hit);
			res.direction = tcd_pkg::DIR_NONE;
		end else begin
			res.crosses   = (dir != tcd_pkg::DIR_NONE);
			res.direction = dir;
		end
	end

endmodule

`default_nettype wire

>>> hdl/tripwire_crossing_direction.sv
// Throughput: one transaction per cycle while the result side is not stalled; the four
// cross products and the decision logic sit in one stage between the input register
// and the result register; an accepted transaction passes through both in that order.
// Reset clears the valid flags of both registers; the payload registers are not reset.
// A stalled result register holds its data; the empty input register still accepts.
`default_nettype none

module tripwire_crossing_direction #(
	parameter int COORD_BITS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	tcd_in_if.sink    items,
	tcd_out_if.source results
);

	logic                  valid_s1;
	logic                  func_s1;
	logic [COORD_BITS-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic                  valid_s2;
	tcd_pkg::tcd_result_t  res_s2;
	tcd_pkg::tcd_result_t  res_comb;
	logic                  adv_s2;
	logic                  adv_s1;

	// Handshake: each stage moves when the one after it is empty or drains.
	assign adv_s2      = !valid_s2 || results.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign items.ready = adv_s1;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= items.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && items.valid) begin
			func_s1 <= items.func;
			sx_s1   <= items.move_start_x;
			sy_s1   <= items.move_start_y;
			ex_s1   <= items.move_end_x;
			ey_s1   <= items.move_end_y;
			ax_s1   <= items.line_a_x;
			ay_s1   <= items.line_a_y;
			bx_s1   <= items.line_b_x;
			by_s1   <= items.line_b_y;
		end
	end

	tcd_geom #(
		.COORD_BITS(COORD_BITS)
	) u_geom (
		.func(func_s1),
		.sx(sx_s1),
		.sy(sy_s1),
		.ex(ex_s1),
		.ey(ey_s1),
		.ax(ax_s1),
		.ay(ay_s1),
		.bx(bx_s1),
		.by(by_s1),
		.res(res_comb)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign results.valid     = valid_s2;
	assign results.crosses   = res_s2.crosses;
	assign results.direction = res_s2.direction;

endmodule

`default_nettype wire

>>> hdl/tcd_checker.sv
`default_nettype none
`include "tripwire_crossing_direction_defines.svh"

// Port-level checks on the tripwire block.
module tcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       crosses,
	input logic [1:0] direction
);

	logic       dir_known;
	logic       dir_shown;
	logic       out_stall;
	logic       in_take;
	logic [2:0] rbits;

	// Decoded views of the port signals that the properties below look at.
	assign dir_known = (direction == tcd_pkg::DIR_NONE) || (direction == tcd_pkg::DIR_A_TO_B) ||
		(direction == tcd_pkg::DIR_B_TO_A);
	assign dir_shown = out_valid && (direction != tcd_pkg::DIR_NONE);
	assign out_stall = out_valid && !out_ready;
	assign in_take   = in_valid && in_ready;
	assign rbits     = {crosses, direction};

	// The direction code is never the unused value.
	`TCD_ASSERT_SAME(a_dir_code, clk, arst_n, out_valid, dir_known, "bad direction code")

	// A reported direction always comes with the crossing flag.
	`TCD_ASSERT_SAME(a_dir_flag, clk, arst_n, dir_shown, crosses, "direction with no flag")

	// The input side only stalls when the result side is full and stalled.
	`TCD_ASSERT_SAME(a_back_press, clk, arst_n, !in_ready, out_stall, "needless input stall")

	// A stalled result holds its transaction.
	`TCD_ASSERT_NEXT(a_hold, clk, arst_n, out_stall, out_valid && $stable(rbits), "result changed")

	// Input taken during a result stall: the pending result is not lost.
	`TCD_ASSERT_NEXT(a_no_loss, clk, arst_n, in_take && out_stall, out_valid, "result dropped")

endmodule

bind tripwire_crossing_direction tcd_checker u_tcd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(items.valid),
	.in_ready(items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.crosses(results.crosses),
	.direction(results.direction)
);

`default_nettype wire
